FILE: rtl/jac_pkg.sv
// ----------------------------------------------------------------------------
// jac_pkg
// Shared types and constants for the joystick axes to cursor motion unit.
// ----------------------------------------------------------------------------
package jac_pkg;

    localparam int ADC_BITS_DEF = 10;

    // Bit-serial quotient length: percentages and q never exceed 100.
    localparam int DIGITS  = 7;
    localparam int CNT_W   = $clog2(DIGITS);
    localparam int PCT_W   = 7;
    localparam int SPD_W   = 8;
    localparam int FACT_W  = 15;    // pct * max_speed
    localparam int PROD_W  = 22;    // pct * max_speed * q
    localparam int RCP_IN_W = 14;   // below the saturation limit
    localparam int RCP_K_W = 13;
    localparam int RCP_W   = RCP_IN_W + RCP_K_W;
    localparam int RCP_SH  = 19;

    localparam logic [PCT_W-1:0]    PCT_FULL   = 7'd100;
    localparam logic [PROD_W-1:0]   SAT_LIM    = 22'd12800;  // 128 * 100
    localparam logic [RCP_K_W-1:0]  RCP_K      = 13'd5243;   // ~2^19 / 100
    localparam logic [PCT_W-1:0]    SPEED_MAX  = 7'd127;
    localparam logic [6:0]          TICK_MAX   = 7'd127;
    localparam logic [6:0]          INTERVAL_RESET = 7'd100;
    localparam logic [SPD_W-1:0]    INTERVAL_BASE  = 8'd100;
    localparam logic signed [SPD_W-1:0] DIR_THRESH = 8'sd5;

    localparam logic [7:0] MAX_SPEED_RESET = 8'd2;
    localparam logic [7:0] SPEED_DIV_RESET = 8'd20;

    localparam int NUM_AXES = 4;
    localparam int OUT_W    = 40;

    typedef enum logic [2:0] {
        REG_X_ORIGIN,
        REG_Y_ORIGIN,
        REG_X2_ORIGIN,
        REG_Y2_ORIGIN,
        REG_AXIS_MIN,
        REG_AXIS_MAX,
        REG_MAX_SPEED,
        REG_SPEED_DIV
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PCT,
        ST_MUL,
        ST_QDIV,
        ST_FIN1,
        ST_FIN2,
        ST_DIR,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic load;
        logic pct_step;
        logic mul;
        logic q_step;
        logic fin1;
        logic fin2;
    } lane_ctrl_t;

endpackage

FILE: rtl/jac_axis_lane.sv
// ----------------------------------------------------------------------------
// jac_axis_lane
// One axis: bit-serial percentage divider, bit-serial magnitude divider with
// Horner accumulation of the speed product, then divide by 100 and saturate.
// ----------------------------------------------------------------------------
module jac_axis_lane #(
    parameter int ADC_BITS = jac_pkg::ADC_BITS_DEF
) (
    input  logic                           clk,
    input  jac_pkg::lane_ctrl_t            ctrl,
    input  logic [ADC_BITS-1:0]            sample,
    input  logic [ADC_BITS-1:0]            origin,
    input  logic [ADC_BITS-1:0]            axis_min,
    input  logic [ADC_BITS-1:0]            axis_max,
    input  logic [7:0]                     max_speed,
    input  logic [7:0]                     divisor,
    output logic [jac_pkg::SPD_W-1:0]      speed
);
    import jac_pkg::*;

    localparam int REM_W = ADC_BITS + 7;
    localparam int DSH_W = ADC_BITS + 6;

    logic                 neg_reg, neg_next;
    logic                 zero_reg, zero_next;
    logic                 clamp_reg, clamp_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [DSH_W-1:0]     dsh_reg, dsh_next;
    logic [PCT_W-1:0]     quo_reg, quo_next;
    logic [FACT_W-1:0]    fact_reg, fact_next;
    logic [PCT_W-1:0]     rem2_reg, rem2_next;
    logic [13:0]          dsh2_reg, dsh2_next;
    logic [PROD_W-1:0]    acc_reg, acc_next;
    logic                 sat_reg, sat_next;
    logic [RCP_W-1:0]     rcp_reg, rcp_next;
    logic [SPD_W-1:0]     speed_reg, speed_next;

    logic                 neg;
    logic [ADC_BITS-1:0]  delta;
    logic [ADC_BITS:0]    span;
    logic                 span_ok;
    logic                 ge1, ge2;
    logic [PCT_W-1:0]     pct;
    logic [PCT_W-1:0]     mag;

    always_comb
    begin
        neg     = sample < origin;
        delta   = neg ? (origin - sample) : (sample - origin);
        span    = neg ? ({1'b0, origin} - {1'b0, axis_min})
                      : ({1'b0, axis_max} - {1'b0, origin});
        span_ok = !span[ADC_BITS] && (span[ADC_BITS-1:0] != '0);
        ge1     = rem_reg >= REM_W'(dsh_reg);
        ge2     = {7'd0, rem2_reg} >= dsh2_reg;
        pct     = zero_reg ? '0 : (clamp_reg ? PCT_FULL : quo_reg);
        mag     = sat_reg ? SPEED_MAX : rcp_reg[RCP_SH +: PCT_W];
    end

    always_comb
    begin
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        clamp_next = clamp_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        quo_next   = quo_reg;
        fact_next  = fact_reg;
        rem2_next  = rem2_reg;
        dsh2_next  = dsh2_reg;
        acc_next   = acc_reg;
        sat_next   = sat_reg;
        rcp_next   = rcp_reg;
        speed_next = speed_reg;
        if (ctrl.load)
        begin
            neg_next   = neg;
            zero_next  = (sample == origin) || !span_ok;
            clamp_next = delta >= span[ADC_BITS-1:0];
            // 100 * delta as 64 + 32 + 4
            rem_next   = REM_W'({delta, 6'd0}) + REM_W'({delta, 5'd0})
                       + REM_W'({delta, 2'd0});
            dsh_next   = {span[ADC_BITS-1:0], 6'd0};
            quo_next   = '0;
        end
        else if (ctrl.pct_step)
        begin
            if (ge1)
                rem_next = rem_reg - REM_W'(dsh_reg);
            dsh_next = dsh_reg >> 1;
            quo_next = {quo_reg[PCT_W-2:0], ge1};
        end
        else if (ctrl.mul)
        begin
            fact_next = FACT_W'(pct) * FACT_W'(max_speed);
            rem2_next = pct;
            dsh2_next = {divisor, 6'd0};
            acc_next  = '0;
        end
        else if (ctrl.q_step)
        begin
            // quotient bits come MSB first: acc = 2*acc + bit*fact
            if (ge2)
                rem2_next = rem2_reg - dsh2_reg[PCT_W-1:0];
            dsh2_next = dsh2_reg >> 1;
            acc_next  = {acc_reg[PROD_W-2:0], 1'b0}
                      + (ge2 ? PROD_W'(fact_reg) : '0);
        end
        else if (ctrl.fin1)
        begin
            sat_next = acc_reg >= SAT_LIM;
            rcp_next = RCP_W'(acc_reg[RCP_IN_W-1:0]) * RCP_W'(RCP_K);
        end
        else if (ctrl.fin2)
        begin
            speed_next = neg_reg ? SPD_W'(-{1'b0, mag}) : {1'b0, mag};
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        zero_reg  <= zero_next;
        clamp_reg <= clamp_next;
        rem_reg   <= rem_next;
        dsh_reg   <= dsh_next;
        quo_reg   <= quo_next;
        fact_reg  <= fact_next;
        rem2_reg  <= rem2_next;
        dsh2_reg  <= dsh2_next;
        acc_reg   <= acc_next;
        sat_reg   <= sat_next;
        rcp_reg   <= rcp_next;
        speed_reg <= speed_next;
    end

    assign speed = speed_reg;

endmodule

FILE: rtl/joystick_axes_to_cursor_motion_unit.sv
// ----------------------------------------------------------------------------
// joystick_axes_to_cursor_motion_unit
// Tick counter, report sequencer, four bit-serial axis lanes, direction step.
// ----------------------------------------------------------------------------
// Tick without report: accept goes straight to the result write state.
// Report tick: load, the two 7-step bit-serial dividers in each axis lane,
//   the finish steps and the direction step come before the result write.
// One item in flight; s_axis_tready is high only while the sequencer idles.
// Reset: tick count 0, report interval 100, registers to defaults, output empty.
module joystick_axes_to_cursor_motion_unit #(
    parameter int ADC_BITS = jac_pkg::ADC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // x_raw, y_raw, x2_raw, y2_raw, button_level, zero pad
    input  logic [((4*ADC_BITS+8)/8)*8-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // x_speed, y_speed, x2_speed, y2_speed, dir_left, dir_right, dir_up,
    // dir_down, pressed, updated, zero pad
    output logic [jac_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_addr,
    input  logic [(ADC_BITS > 8 ? ADC_BITS : 8)-1:0] cfg_data
);
    import jac_pkg::*;

    localparam logic [ADC_BITS-1:0] ORIGIN_RESET = ADC_BITS'(1) << (ADC_BITS - 1);
    localparam logic [ADC_BITS-1:0] AXIS_TOP     = '1;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [6:0]           ticks_reg, ticks_next;
    logic [6:0]           interval_reg, interval_next;
    logic [ADC_BITS-1:0]  origin_reg [NUM_AXES];
    logic [ADC_BITS-1:0]  amin_reg, amax_reg;
    logic [7:0]           max_speed_reg, speed_div_reg;
    logic [ADC_BITS-1:0]  smp_reg [NUM_AXES];
    logic                 pressed_reg;
    logic                 updated_reg;
    logic signed [SPD_W-1:0] v_reg, v_next, w_reg, w_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     out_data_reg;

    lane_ctrl_t           ctrl;
    logic                 in_fire, out_load;
    logic [SPD_W-1:0]     lane_speed [NUM_AXES];
    logic [7:0]           div_eff;
    logic [6:0]           ticks_inc;
    logic                 report;
    logic [15:0]          vprod, wprod;
    logic signed [SPD_W-1:0] m_sel;
    logic [SPD_W-1:0]     m_mag;
    logic [SPD_W-1:0]     spd [NUM_AXES];

    assign div_eff   = (speed_div_reg == 8'd0) ? 8'd1 : speed_div_reg;
    assign ticks_inc = (ticks_reg == TICK_MAX) ? TICK_MAX : ticks_reg + 7'd1;
    assign report    = ticks_inc > interval_reg;
    assign in_fire   = s_axis_tvalid && s_axis_tready;

    generate
        for (genvar i = 0; i < NUM_AXES; i++)
        begin : g_lane
            jac_axis_lane #(
                .ADC_BITS (ADC_BITS)
            ) u_lane (
                .clk       (clk),
                .ctrl      (ctrl),
                .sample    (smp_reg[i]),
                .origin    (origin_reg[i]),
                .axis_min  (amin_reg),
                .axis_max  (amax_reg),
                .max_speed (max_speed_reg),
                .divisor   (div_eff),
                .speed     (lane_speed[i])
            );
            assign spd[i] = updated_reg ? lane_speed[i] : '0;
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_axis_tvalid) state_next = report ? ST_LOAD : ST_WRITE;
            ST_LOAD:  state_next = ST_PCT;
            ST_PCT:   if (cnt_reg == '0) state_next = ST_MUL;
            ST_MUL:   state_next = ST_QDIV;
            ST_QDIV:  if (cnt_reg == '0) state_next = ST_FIN1;
            ST_FIN1:  state_next = ST_FIN2;
            ST_FIN2:  state_next = ST_DIR;
            ST_DIR:   state_next = ST_WRITE;
            ST_WRITE: if (!out_valid_reg || m_axis_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        ctrl          = '0;
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        cnt_next      = cnt_reg;
        unique case (state_reg)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_LOAD:
            begin
                ctrl.load = 1'b1;
                cnt_next  = CNT_W'(DIGITS - 1);
            end
            ST_PCT:
            begin
                ctrl.pct_step = 1'b1;
                cnt_next      = cnt_reg - CNT_W'(1);
            end
            ST_MUL:
            begin
                ctrl.mul = 1'b1;
                cnt_next = CNT_W'(DIGITS - 1);
            end
            ST_QDIV:
            begin
                ctrl.q_step = 1'b1;
                cnt_next    = cnt_reg - CNT_W'(1);
            end
            ST_FIN1:  ctrl.fin1 = 1'b1;
            ST_FIN2:  ctrl.fin2 = 1'b1;
            ST_DIR:   ;
            ST_WRITE: out_load = !out_valid_reg || m_axis_tready;
            default:  ;
        endcase
    end

    // direction step, report interval, tick counter and output valid
    always_comb
    begin
        vprod   = 16'(lane_speed[0]) * 16'(div_eff);
        wprod   = 16'(lane_speed[1]) * 16'(div_eff);
        v_next  = v_reg;
        w_next  = w_reg;
        if (in_fire)
        begin
            v_next = '0;
            w_next = '0;
        end
        else if (state_reg == ST_DIR)
        begin
            v_next = vprod[7:0];
            w_next = wprod[7:0];
        end

        m_sel = (v_reg != '0) ? v_reg : w_reg;
        m_mag = m_sel[SPD_W-1] ? SPD_W'(-m_sel) : m_sel;
        interval_next = interval_reg;
        if (out_load && (v_reg != '0 || w_reg != '0))
            interval_next = (m_mag >= INTERVAL_BASE) ? 7'd1
                                                     : 7'(INTERVAL_BASE - m_mag);

        ticks_next = ticks_reg;
        if (in_fire)
            ticks_next = report ? 7'd0 : ticks_inc;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ticks_reg     <= '0;
            interval_reg  <= INTERVAL_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++)
                origin_reg[i] <= ORIGIN_RESET;
            amin_reg      <= '0;
            amax_reg      <= AXIS_TOP;
            max_speed_reg <= MAX_SPEED_RESET;
            speed_div_reg <= SPEED_DIV_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ticks_reg     <= ticks_next;
            interval_reg  <= interval_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_X_ORIGIN:  origin_reg[0] <= cfg_data[ADC_BITS-1:0];
                    REG_Y_ORIGIN:  origin_reg[1] <= cfg_data[ADC_BITS-1:0];
                    REG_X2_ORIGIN: origin_reg[2] <= cfg_data[ADC_BITS-1:0];
                    REG_Y2_ORIGIN: origin_reg[3] <= cfg_data[ADC_BITS-1:0];
                    REG_AXIS_MIN:  amin_reg      <= cfg_data[ADC_BITS-1:0];
                    REG_AXIS_MAX:  amax_reg      <= cfg_data[ADC_BITS-1:0];
                    REG_MAX_SPEED: max_speed_reg <= cfg_data[7:0];
                    REG_SPEED_DIV: speed_div_reg <= cfg_data[7:0];
                    default:       ;
                endcase
            end
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        w_reg <= w_next;
        if (in_fire)
        begin
            for (int i = 0; i < NUM_AXES; i++)
                smp_reg[i] <= s_axis_tdata[i*ADC_BITS +: ADC_BITS];
            pressed_reg <= !s_axis_tdata[NUM_AXES*ADC_BITS];
            updated_reg <= report;
        end
        if (out_load)
            out_data_reg <= {2'b00, updated_reg, pressed_reg,
                             w_reg < -DIR_THRESH, w_reg > DIR_THRESH,
                             v_reg < -DIR_THRESH, v_reg > DIR_THRESH,
                             spd[3], spd[2], spd[1], spd[0]};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // no report means all speeds zero and no direction
    a_idle_speeds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[37] |-> m_axis_tdata[35:0] == '0)
        else $error("speeds or directions set on a tick without report");

    a_interval_range: assert property (@(posedge clk) disable iff (!rst_n)
        interval_reg != 7'd0 && interval_reg <= INTERVAL_RESET)
        else $error("report interval out of range");

    a_tick_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && report |=> ticks_reg == 7'd0 && state_reg == ST_LOAD)
        else $error("report tick did not restart counter and sequencer");

    a_interval_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_WRITE |=> $stable(interval_reg))
        else $error("report interval changed outside result write");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams millisecond ticks of joystick samples into the cursor motion unit
// and checks every result item against an in-bench model of the tick counter,
// the axis scaling and the direction step, over several register settings.
// ----------------------------------------------------------------------------
module tb;
    import jac_pkg::*;

    localparam int ADC_W      = 10;
    localparam int TICK_W     = ((4*ADC_W+8)/8)*8;
    localparam int WDOG_LIMIT = 2000;
    localparam int PRINT_MAX  = 40;

    typedef struct {
        logic [7:0] x_spd;
        logic [7:0] y_spd;
        logic [7:0] x2_spd;
        logic [7:0] y2_spd;
        logic       left;
        logic       right;
        logic       up;
        logic       down;
        logic       pressed;
        logic       updated;
    } motion_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [TICK_W-1:0] s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              cfg_we = 1'b0;
    logic [2:0]        cfg_addr = REG_X_ORIGIN;
    logic [9:0]        cfg_data = '0;

    // pending ticks and the motions they should produce
    logic [TICK_W-1:0] tick_q[$];
    motion_t           motion_q[$];

    // model state and register copy
    int x_org, y_org, x2_org, y2_org, lo_lim, hi_lim, spd_gain, spd_div;
    int tick_cnt, report_ivl;

    int send_idle_pct = 30;
    int recv_idle_pct = 72;
    int ticks_pushed  = 0;
    int ticks_taken   = 0;
    int report_cnt    = 0;
    int write_cnt     = 0;
    int err_cnt       = 0;
    int stall_cycles  = 0;

    joystick_axes_to_cursor_motion_unit #(
        .ADC_BITS (ADC_W)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Motion model
    // ------------------------------------------------------------------
    function automatic int axis_pct(int raw, int org);
        int  delta;
        int  span;
        int  pct;
        bit  neg;
        if (raw == org)
            return 0;
        neg   = (raw < org);
        delta = neg ? org - raw : raw - org;
        span  = neg ? org - lo_lim : hi_lim - org;
        if (span <= 0)
            return 0;
        pct = (100 * delta) / span;
        if (pct > 100)
            pct = 100;
        return neg ? -pct : pct;
    endfunction

    function automatic int axis_speed(int raw, int org);
        int c;
        int mag;
        int q;
        int s;
        c   = axis_pct(raw, org);
        mag = (c < 0) ? -c : c;
        q   = mag / ((spd_div == 0) ? 1 : spd_div);
        s   = (c * spd_gain * q) / 100;
        if (s > 127)
            s = 127;
        if (s < -127)
            s = -127;
        return s;
    endfunction

    function automatic int wrap_byte(int val);
        logic signed [7:0] b;
        b = val[7:0];
        return int'(b);
    endfunction

    // advances the tick counter and returns the motion for one tick
    function automatic motion_t predict_motion(logic [TICK_W-1:0] d);
        motion_t m;
        int      sx, sy, sx2, sy2;
        int      v, w, mag, dv, ivl;
        sx  = 0;
        sy  = 0;
        sx2 = 0;
        sy2 = 0;
        dv  = (spd_div == 0) ? 1 : spd_div;
        m.updated = 1'b0;
        if (tick_cnt < 127)
            tick_cnt++;
        if (tick_cnt > report_ivl)
        begin
            tick_cnt  = 0;
            m.updated = 1'b1;
            sx  = axis_speed(int'(d[9:0]),   x_org);
            sy  = axis_speed(int'(d[19:10]), y_org);
            sx2 = axis_speed(int'(d[29:20]), x2_org);
            sy2 = axis_speed(int'(d[39:30]), y2_org);
        end
        v = wrap_byte(sx * dv);
        w = wrap_byte(sy * dv);
        if (v != 0 || w != 0)
        begin
            mag = (v != 0) ? v : w;
            if (mag < 0)
                mag = -mag;
            ivl = 100 - mag;
            if (ivl <= 0)
                ivl = 1;
            report_ivl = ivl;
        end
        m.x_spd   = sx[7:0];
        m.y_spd   = sy[7:0];
        m.x2_spd  = sx2[7:0];
        m.y2_spd  = sy2[7:0];
        m.left    = (v > 5);
        m.right   = (v < -5);
        m.up      = (w > 5);
        m.down    = (w < -5);
        m.pressed = ~d[40];
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------
    task automatic report_error(string msg);
        if (err_cnt < PRINT_MAX)
            $display("tb: error at %0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic check_field(string name, logic [7:0] got_v, logic [7:0] want_v);
        if (got_v !== want_v)
            report_error($sformatf("result %0d %s got %h expected %h",
                                   ticks_taken - motion_q.size(), name, got_v, want_v));
    endtask

    // ------------------------------------------------------------------
    // Tick driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (tick_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= tick_q.pop_front();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: register copy, prediction, comparison, watchdog
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        motion_t got;
        motion_t want;
        bit      progress;
        if (!rst_n)
        begin
            x_org      = 512;
            y_org      = 512;
            x2_org     = 512;
            y2_org     = 512;
            lo_lim     = 0;
            hi_lim     = 1023;
            spd_gain   = 2;
            spd_div    = 20;
            tick_cnt   = 0;
            report_ivl = 100;
        end
        else
        begin
            progress = 1'b0;
            if (cfg_we)
            begin
                progress = 1'b1;
                write_cnt++;
                case (cfg_addr)
                    REG_X_ORIGIN:  x_org    = cfg_data;
                    REG_Y_ORIGIN:  y_org    = cfg_data;
                    REG_X2_ORIGIN: x2_org   = cfg_data;
                    REG_Y2_ORIGIN: y2_org   = cfg_data;
                    REG_AXIS_MIN:  lo_lim   = cfg_data;
                    REG_AXIS_MAX:  hi_lim   = cfg_data;
                    REG_MAX_SPEED: spd_gain = cfg_data[7:0];
                    REG_SPEED_DIV: spd_div  = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                progress = 1'b1;
                want = predict_motion(s_axis_tdata);
                if (want.updated)
                    report_cnt++;
                motion_q.push_back(want);
                ticks_taken++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                progress    = 1'b1;
                got.x_spd   = m_axis_tdata[7:0];
                got.y_spd   = m_axis_tdata[15:8];
                got.x2_spd  = m_axis_tdata[23:16];
                got.y2_spd  = m_axis_tdata[31:24];
                got.left    = m_axis_tdata[32];
                got.right   = m_axis_tdata[33];
                got.up      = m_axis_tdata[34];
                got.down    = m_axis_tdata[35];
                got.pressed = m_axis_tdata[36];
                got.updated = m_axis_tdata[37];
                if (motion_q.size() == 0)
                    report_error($sformatf("result %h with no tick pending", m_axis_tdata));
                else
                begin
                    want = motion_q.pop_front();
                    check_field("x_speed",   got.x_spd,   want.x_spd);
                    check_field("y_speed",   got.y_spd,   want.y_spd);
                    check_field("x2_speed",  got.x2_spd,  want.x2_spd);
                    check_field("y2_speed",  got.y2_spd,  want.y2_spd);
                    check_field("dir_left",  got.left,    want.left);
                    check_field("dir_right", got.right,   want.right);
                    check_field("dir_up",    got.up,      want.up);
                    check_field("dir_down",  got.down,    want.down);
                    check_field("pressed",   got.pressed, want.pressed);
                    check_field("updated",   got.updated, want.updated);
                end
            end
            stall_cycles = progress ? 0 : stall_cycles + 1;
            if (stall_cycles >= WDOG_LIMIT)
            begin
                $display("tb: no progress for %0d cycles", WDOG_LIMIT);
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic cfg_write(cfg_reg_t r, int val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= r;
        cfg_data <= val[9:0];
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic set_config(int xo, int yo, int x2o, int y2o,
                              int lo, int hi, int gain, int dv);
        cfg_write(REG_X_ORIGIN,  xo);
        cfg_write(REG_Y_ORIGIN,  yo);
        cfg_write(REG_X2_ORIGIN, x2o);
        cfg_write(REG_Y2_ORIGIN, y2o);
        cfg_write(REG_AXIS_MIN,  lo);
        cfg_write(REG_AXIS_MAX,  hi);
        cfg_write(REG_MAX_SPEED, gain);
        cfg_write(REG_SPEED_DIV, dv);
    endtask

    task automatic push_tick(int x, int y, int x2, int y2, int btn);
        tick_q.push_back({7'd0, btn[0], y2[9:0], x2[9:0], y[9:0], x[9:0]});
        ticks_pushed++;
    endtask

    // with a full report rate every other tick reports, so a pair hits one
    task automatic push_pair(int x, int y, int x2, int y2, int btn);
        push_tick(x, y, x2, y2, btn);
        push_tick(x, y, x2, y2, btn);
    endtask

    task automatic drain();
        while (ticks_taken != ticks_pushed || motion_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic int rand_axis();
        case ($urandom_range(7, 0))
            0:       return 0;
            1:       return 1023;
            default: return $urandom_range(1023, 0);
        endcase
    endfunction

    function automatic int rand_origin();
        case ($urandom_range(3, 0))
            0:       return 0;
            1:       return 1023;
            default: return $urandom_range(1023, 0);
        endcase
    endfunction

    initial
    begin
        int p;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset register values: crosses the first report at tick 101
        repeat (110) push_tick(rand_axis(), rand_axis(), rand_axis(), rand_axis(),
                               $urandom_range(1, 0));
        drain();

        // full gain, unit divisor: a full X deflection pins the interval at 1
        set_config(512, 512, 512, 512, 0, 1023, 255, 1);
        while (report_ivl != 1)
        begin
            push_tick(1023, rand_axis(), rand_axis(), rand_axis(), $urandom_range(1, 0));
            drain();
        end

        push_pair(1023, 1023, 1023, 1023, 1);
        push_pair(0,    0,    0,    0,    0);
        push_pair(1023, 512,  512,  512,  0);
        push_pair(0,    513,  511,  1022, 1);
        push_pair(1023, 600,  400,  700,  1);
        push_pair(0,    1023, 0,    1023, 0);
        drain();

        // zero divisor, zero and negative ranges on Y, X2 and Y2
        set_config(512, 200, 800, 700, 300, 700, 255, 0);
        push_pair(1023, 100, 900, 900, 0);
        push_pair(0,    250, 750, 300, 1);
        drain();

        for (p = 0; p < 6; p++)
        begin
            if (p == 2)
            begin
                send_idle_pct = 72;
                recv_idle_pct = 30;
            end
            if (p == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (p)
                0: set_config(0, 0, 0, 0, 0, 1023, 255, 1);
                1: set_config(1023, 1023, 1023, 1023, 0, 1023, 0, 255);
                default:
                    set_config(rand_origin(), rand_origin(), rand_origin(), rand_origin(),
                               ($urandom_range(3, 0) == 0) ? $urandom_range(1023, 0)
                                                           : $urandom_range(300, 0),
                               ($urandom_range(3, 0) == 0) ? $urandom_range(1023, 0)
                                                           : $urandom_range(1023, 700),
                               ($urandom_range(3, 0) == 0) ? 255 : $urandom_range(255, 0),
                               ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1));
            endcase
            repeat (45) push_tick(rand_axis(), rand_axis(), rand_axis(), rand_axis(),
                                  $urandom_range(1, 0));
            drain();
        end

        repeat (25) @(posedge clk);
        $display("tb: %0d ticks checked, %0d of them axis reports, %0d register writes",
                 ticks_taken, report_cnt, write_cnt);
        $display("tb: %0d field errors", err_cnt);
        if (err_cnt == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/jac_pkg.sv
rtl/jac_axis_lane.sv
rtl/joystick_axes_to_cursor_motion_unit.sv
tb/tb.sv
